// ----- design/qcbp_pkg.sv -----
`timescale 1ns / 1ps
// shared types, constants and helpers for the quantized code bit packer
// no dependencies; imported by every module of the block

package qcbp_pkg;

  localparam int GroupCodes = 64;
  localparam int SmallGroup = 16;
  localparam int CodeW      = 7;
  localparam int CountW     = 7;
  localparam int IdxW       = 6;
  localparam int WordW      = 64;
  localparam int WidxW      = 3;

  // effective packing modes, bits per code
  typedef enum logic [2:0] {
    MODE_2 = 3'd2,
    MODE_3 = 3'd3,
    MODE_4 = 3'd4,
    MODE_5 = 3'd5,
    MODE_6 = 3'd6,
    MODE_7 = 3'd7
  } mode_e;

  // one bit plane per code bit, lane k holds code k
  typedef logic [CodeW-1:0][GroupCodes-1:0] plane_set_t;

  typedef struct packed {
    logic [CountW-1:0] count;
    mode_e             mode;
    logic              vec_last;
  } grp_desc_t;

  typedef struct packed {
    logic             wr_en;
    logic [IdxW-1:0]  wr_idx;
    logic [CodeW-1:0] code;
    logic             push;
    grp_desc_t        desc;
  } wr_req_t;

  typedef struct packed {
    logic       wr_ready;
    logic       rd_valid;
    logic [1:0] full;
  } q_status_t;

  function automatic logic [WidxW-1:0] words_per_group(mode_e mode);
    logic [WidxW-1:0] nw;
    case (mode)
      MODE_2:  nw = 3'd2;
      MODE_3:  nw = 3'd3;
      MODE_4:  nw = 3'd1;
      MODE_5:  nw = 3'd5;
      MODE_6:  nw = 3'd6;
      MODE_7:  nw = 3'd7;
      default: nw = 3'd2;
    endcase
    return nw;
  endfunction

endpackage

// ----- design/quantized_code_bit_packer.sv -----
`timescale 1ns / 1ps
// top level of the quantized code bit packer: front end, group queue and back end
// depends on qcbp_pkg, qcbp_front, qcbp_grp_queue, qcbp_back

// Takes one 7-bit code per cycle and gathers 64 codes (16 in 4-bit mode) into
// bit-plane banks; a group ends when full or at the code flagged last_code, and
// partial groups are zero-padded. Each finished group leaves as 1 to 7 packed
// 64-bit words (1 word for 4-bit mode, otherwise as many as code_bits), one word
// per cycle from a registered output unless stalled. Codes are accepted at one
// per cycle as long as one of the two group banks is free: a full group's words
// drain while the next group fills, so the input only stalls when groups end
// faster than their words are taken (short vectors, or a stalled output). The
// mode register is sampled when a group ends; values below 2 pack as 2-bit mode.

module quantized_code_bit_packer import qcbp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [2:0]       cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [CodeW-1:0] code_value_i,
  input  logic             last_code_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [WordW-1:0] packed_word_o,
  output logic             group_last_o,
  output logic             vector_last_o
);

  wr_req_t    wr_req;
  q_status_t  q_status;
  plane_set_t rd_planes;
  grp_desc_t  rd_desc;
  logic       pop;

  qcbp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .code_value_i (code_value_i),
    .last_code_i  (last_code_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .wr_ready_i   (q_status.wr_ready),
    .wr_o         (wr_req)
  );

  qcbp_grp_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_i        (wr_req),
    .pop_i       (pop),
    .status_o    (q_status),
    .rd_planes_o (rd_planes),
    .rd_desc_o   (rd_desc)
  );

  qcbp_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .rd_valid_i    (q_status.rd_valid),
    .rd_planes_i   (rd_planes),
    .rd_desc_i     (rd_desc),
    .pop_o         (pop),
    .packed_word_o (packed_word_o),
    .group_last_o  (group_last_o),
    .vector_last_o (vector_last_o),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i)
  );

  // no new code while both banks hold finished groups
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($countones(q_status.full) == 2) |-> !in_ready_o)
    else $error("code accepted with both group banks full");

  // a group's bank stays held until its final word has been loaded
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !group_last_o) |-> q_status.rd_valid)
    else $error("group bank released before its final word");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && vector_last_o) |-> group_last_o)
    else $error("vector end flagged on a non-final word");

  // a bank is released only as its final word is loaded into the output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> (out_valid_o && group_last_o))
    else $error("group released without its final word");

endmodule

// ----- design/qcbp_front.sv -----
`timescale 1ns / 1ps
// front end: mode register, code acceptance, fill count and group end detection
// depends on qcbp_pkg

module qcbp_front import qcbp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [2:0]       cfg_wdata_i,
  input  logic [CodeW-1:0] code_value_i,
  input  logic             last_code_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             wr_ready_i,
  output wr_req_t          wr_o
);

  logic [2:0]        cfg_q, cfg_d;
  logic [CountW-1:0] fill_q, fill_d;
  logic [CountW-1:0] fill_inc;
  mode_e             mode;
  logic              accept;
  logic              grp_full;
  logic              done;

  always_comb begin
    cfg_d    = cfg_we_i ? cfg_wdata_i : cfg_q;
    mode     = (cfg_q < 3'(MODE_2)) ? MODE_2 : mode_e'(cfg_q);
    accept   = in_valid_i && wr_ready_i;
    fill_inc = fill_q + 7'd1;
    grp_full = (mode == MODE_4) ? (fill_inc >= CountW'(SmallGroup))
                                : (fill_inc >= CountW'(GroupCodes));
    done     = grp_full || last_code_i;

    wr_o.wr_en         = accept;
    wr_o.wr_idx        = fill_q[IdxW-1:0];
    wr_o.code          = code_value_i;
    wr_o.push          = accept && done;
    // a group grown past 16 before switching to 4-bit mode keeps its first 16
    wr_o.desc.count    = (mode == MODE_4 && fill_inc > CountW'(SmallGroup))
                         ? CountW'(SmallGroup) : fill_inc;
    wr_o.desc.mode     = mode;
    wr_o.desc.vec_last = last_code_i;

    fill_d = fill_q;
    if (accept) begin
      fill_d = done ? '0 : fill_inc;
    end
  end

  assign in_ready_o = wr_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q  <= 3'(MODE_2);
      fill_q <= '0;
    end else begin
      cfg_q  <= cfg_d;
      fill_q <= fill_d;
    end
  end

endmodule

// ----- design/qcbp_grp_queue.sv -----
`timescale 1ns / 1ps
// two-entry group queue: bit-plane banks filled code by code, drained as whole groups
// depends on qcbp_pkg

module qcbp_grp_queue import qcbp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  wr_req_t    wr_i,
  input  logic       pop_i,
  output q_status_t  status_o,
  output plane_set_t rd_planes_o,
  output grp_desc_t  rd_desc_o
);

  plane_set_t bank_q [2];
  grp_desc_t  desc_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] full_q, full_d;

  always_comb begin
    full_d   = full_q;
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (wr_i.push) begin
      full_d[wr_ptr_q] = 1'b1;
      wr_ptr_d         = ~wr_ptr_q;
    end
    if (pop_i) begin
      full_d[rd_ptr_q] = 1'b0;
      rd_ptr_d         = ~rd_ptr_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q   <= '0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      full_q   <= full_d;
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
    end
  end

  // each code is scattered into its lane of every plane
  always_ff @(posedge clk_i) begin
    if (wr_i.wr_en) begin
      for (int b = 0; b < CodeW; b++) begin
        bank_q[wr_ptr_q][b][wr_i.wr_idx] <= wr_i.code[b];
      end
    end
    if (wr_i.push) begin
      desc_q[wr_ptr_q] <= wr_i.desc;
    end
  end

  assign status_o.wr_ready = !full_q[wr_ptr_q];
  assign status_o.rd_valid = full_q[rd_ptr_q];
  assign status_o.full     = full_q;
  assign rd_planes_o       = bank_q[rd_ptr_q];
  assign rd_desc_o         = desc_q[rd_ptr_q];

endmodule

// ----- design/qcbp_back.sv -----
`timescale 1ns / 1ps
// back end: forms the packed words of the head group one per cycle unless stalled, into an output register
// depends on qcbp_pkg

module qcbp_back import qcbp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rd_valid_i,
  input  plane_set_t       rd_planes_i,
  input  grp_desc_t        rd_desc_i,
  output logic             pop_o,
  output logic [WordW-1:0] packed_word_o,
  output logic             group_last_o,
  output logic             vector_last_o,
  output logic             out_valid_o,
  input  logic             out_ready_i
);

  logic [WidxW-1:0]      widx_q, widx_d;
  logic                  out_valid_q, out_valid_d;
  logic [WordW-1:0]      word_q;
  logic                  grp_last_q;
  logic                  vec_last_q;

  logic [GroupCodes-1:0] mask;
  logic [CodeW-1:0]      code_c [GroupCodes];
  logic [7:0]            bytes2 [16];
  logic [7:0]            bytes5 [32];
  logic [7:0]            bytes6 [64];
  logic [WordW-1:0]      word4, w2, w5, w6;
  logic [WordW-1:0]      word;
  logic [WidxW-1:0]      nw;
  logic                  fin;
  logic                  load;

  always_comb begin
    // lanes at or beyond the fill count read as zero codes
    for (int k = 0; k < GroupCodes; k++) begin
      mask[k] = CountW'(k) < rd_desc_i.count;
      for (int b = 0; b < CodeW; b++) begin
        code_c[k][b] = rd_planes_i[b][k] & mask[k];
      end
    end

    for (int i = 0; i < 16; i++) begin
      bytes2[i] = {code_c[48+i][1:0], code_c[32+i][1:0],
                   code_c[16+i][1:0], code_c[i][1:0]};
      bytes5[i]    = {code_c[16+i][3:0], code_c[i][3:0]};
      bytes5[16+i] = {code_c[48+i][3:0], code_c[32+i][3:0]};
      // fourth slice spread over the two high bits of three bytes
      bytes6[i]    = {code_c[48+i][1:0], code_c[i][5:0]};
      bytes6[16+i] = {code_c[48+i][3:2], code_c[16+i][5:0]};
      bytes6[32+i] = {code_c[48+i][5:4], code_c[32+i][5:0]};
      bytes6[48+i] = '0;
    end

    for (int i = 0; i < 8; i++) begin
      word4[8*i +: 8] = {code_c[8+i][3:0], code_c[i][3:0]};
      w2[8*i +: 8]    = bytes2[{widx_q[0], 3'(i)}];
      w5[8*i +: 8]    = bytes5[{widx_q[1:0], 3'(i)}];
      w6[8*i +: 8]    = bytes6[{widx_q, 3'(i)}];
    end

    nw  = words_per_group(rd_desc_i.mode);
    fin = (widx_q == nw - 3'd1);

    case (rd_desc_i.mode)
      MODE_2:  word = w2;
      MODE_3:  word = fin ? (rd_planes_i[2] & mask) : w2;
      MODE_4:  word = word4;
      MODE_5:  word = fin ? (rd_planes_i[4] & mask) : w5;
      MODE_6:  word = w6;
      MODE_7:  word = fin ? (rd_planes_i[6] & mask) : w6;
      default: word = w2;
    endcase

    load        = rd_valid_i && (!out_valid_q || out_ready_i);
    pop_o       = load && fin;
    widx_d      = widx_q;
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
      widx_d      = fin ? '0 : widx_q + 3'd1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      widx_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      widx_q      <= widx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      word_q     <= word;
      grp_last_q <= fin;
      vec_last_q <= fin && rd_desc_i.vec_last;
    end
  end

  assign packed_word_o = word_q;
  assign group_last_o  = grp_last_q;
  assign vector_last_o = vec_last_q;
  assign out_valid_o   = out_valid_q;

endmodule

// ----- test/quantized_code_bit_packer_tb.sv -----
`timescale 1ns / 1ps
// self-checking testbench for quantized_code_bit_packer: random codes in bursts, stalled output
// depends on qcbp_pkg and the design under design/; predicts every packed word on its own

module quantized_code_bit_packer_tb;
  import qcbp_pkg::*;

  localparam int NumPhases   = 11;
  localparam int PhaseCodes  = 10;
  localparam int SettleCycles = 16;
  localparam int MaxReports  = 10;
  localparam int CycleLimit  = 400000;

  typedef struct {
    logic [CodeW-1:0] code;
    logic             last;
  } code_item_t;

  typedef struct {
    logic [WordW-1:0] word;
    logic             group_last;
    logic             vector_last;
  } packed_word_t;

  logic             clk_i         = 1'b0;
  logic             rst_ni        = 1'b0;
  logic             cfg_we_i      = 1'b0;
  logic [2:0]       cfg_wdata_i   = 3'd0;
  logic             in_valid_i    = 1'b0;
  logic             in_ready_o;
  logic [CodeW-1:0] code_value_i  = '0;
  logic             last_code_i   = 1'b0;
  logic             out_valid_o;
  logic             out_ready_i   = 1'b0;
  logic [WordW-1:0] packed_word_o;
  logic             group_last_o;
  logic             vector_last_o;

  code_item_t   pending_codes[$];
  packed_word_t packed_words_due[$];
  code_item_t   next_code;
  packed_word_t due_word;

  // own copy of the block state
  logic [CodeW-1:0] group_store [GroupCodes];
  int unsigned      group_fill    = 0;
  logic [2:0]       code_bits_cfg = 3'd2;

  int unsigned burst_left    = 0;
  int unsigned gap_left      = 0;
  logic [15:0] ready_pattern = '1;
  int unsigned pattern_age   = 0;
  int unsigned error_count   = 0;
  int unsigned cycle_count   = 0;

  logic [2:0] phase_cfg [NumPhases] =
    '{3'd2, 3'd7, 3'd0, 3'd5, 3'd4, 3'd3, 3'd6, 3'd1, 3'd4, 3'd7, 3'd2};

  quantized_code_bit_packer u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .code_value_i  (code_value_i),
    .last_code_i   (last_code_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .packed_word_o (packed_word_o),
    .group_last_o  (group_last_o),
    .vector_last_o (vector_last_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // stores one code and, when the group ends, queues the packed words it yields
  task automatic pack_code(input logic [CodeW-1:0] code, input logic last);
    mode_e        mode;
    int unsigned  grp_size;
    int unsigned  n_codes;
    int unsigned  n_words;
    logic [CodeW-1:0] mask;
    logic [CodeW-1:0] c [GroupCodes];
    logic [7:0]   bytes [56];
    logic [WordW-1:0] words [7];
    packed_word_t res;
    group_store[group_fill % GroupCodes] = code;
    group_fill++;
    mode = (code_bits_cfg < 3'd2) ? MODE_2 : mode_e'(code_bits_cfg);
    grp_size = (mode == MODE_4) ? SmallGroup : GroupCodes;
    if (group_fill < grp_size && !last) return;
    n_codes = (group_fill < grp_size) ? group_fill : grp_size;
    mask = CodeW'((1 << int'(mode)) - 1);
    // positions past the fill count pack as zero
    for (int k = 0; k < GroupCodes; k++)
      c[k] = (k < n_codes) ? (group_store[k] & mask) : '0;
    for (int i = 0; i < 56; i++) bytes[i] = '0;
    case (mode)
      MODE_2, MODE_3: begin
        for (int i = 0; i < 16; i++)
          bytes[i] = {c[48+i][1:0], c[32+i][1:0], c[16+i][1:0], c[i][1:0]};
        n_words = 2;
      end
      MODE_4: begin
        for (int i = 0; i < 8; i++) bytes[i] = {c[8+i][3:0], c[i][3:0]};
        n_words = 1;
      end
      MODE_5: begin
        for (int i = 0; i < 16; i++) begin
          bytes[i]    = {c[16+i][3:0], c[i][3:0]};
          bytes[16+i] = {c[48+i][3:0], c[32+i][3:0]};
        end
        n_words = 4;
      end
      default: begin
        // fourth slice spread over the top two bits of the other three
        for (int i = 0; i < 16; i++) begin
          bytes[i]    = {c[48+i][1:0], c[i][5:0]};
          bytes[16+i] = {c[48+i][3:2], c[16+i][5:0]};
          bytes[32+i] = {c[48+i][5:4], c[32+i][5:0]};
        end
        n_words = 6;
      end
    endcase
    for (int k = 0; k < n_words; k++)
      for (int i = 0; i < 8; i++) words[k][8*i +: 8] = bytes[8*k + i];
    if (mode == MODE_3 || mode == MODE_5 || mode == MODE_7) begin
      for (int k = 0; k < GroupCodes; k++) words[n_words][k] = c[k][int'(mode) - 1];
      n_words++;
    end
    for (int k = 0; k < n_words; k++) begin
      res.word        = words[k];
      res.group_last  = (k == n_words - 1);
      res.vector_last = (k == n_words - 1) && last;
      packed_words_due.push_back(res);
    end
    group_fill = 0;
  endtask

  task automatic queue_codes(input int unsigned len, input logic with_last);
    code_item_t item;
    int unsigned roll;
    for (int n = 0; n < len; n++) begin
      roll = $urandom_range(0, 7);
      item.code = (roll == 0) ? 7'h7f : (roll == 1) ? 7'h00 : CodeW'($urandom);
      item.last = with_last && (n == len - 1);
      pending_codes.push_back(item);
    end
  endtask

  task automatic wait_until_drained();
    while (pending_codes.size() != 0 || in_valid_i || packed_words_due.size() != 0)
      @(posedge clk_i);
  endtask

  // input side: bursts of codes with random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i   <= 1'b0;
      code_value_i <= '0;
      last_code_i  <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) pack_code(code_value_i, last_code_i);
      if (!in_valid_i || in_ready_o) begin
        if (gap_left != 0 || pending_codes.size() == 0) begin
          if (gap_left != 0) gap_left--;
          in_valid_i <= 1'b0;
        end else begin
          next_code = pending_codes.pop_front();
          in_valid_i   <= 1'b1;
          code_value_i <= next_code.code;
          last_code_i  <= next_code.last;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 30);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
    end
  end

  // output side: compare each word taken, stall on a rotating pattern
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (packed_words_due.size() == 0) begin
          error_count++;
          if (error_count <= MaxReports)
            $display("unexpected word %h glast %0b vlast %0b",
                     packed_word_o, group_last_o, vector_last_o);
        end else begin
          due_word = packed_words_due.pop_front();
          if (packed_word_o !== due_word.word || group_last_o !== due_word.group_last ||
              vector_last_o !== due_word.vector_last) begin
            error_count++;
            if (error_count <= MaxReports)
              $display("mismatch: expected %h glast %0b vlast %0b, got %h glast %0b vlast %0b",
                       due_word.word, due_word.group_last, due_word.vector_last,
                       packed_word_o, group_last_o, vector_last_o);
          end
        end
      end
      if (pattern_age == 0) begin
        ready_pattern = ($urandom_range(0, 3) == 0) ? 16'hffff : (16'($urandom) | 16'h0101);
        pattern_age   = $urandom_range(20, 80);
      end else begin
        pattern_age--;
      end
      ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
      out_ready_i <= ready_pattern[0];
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int unsigned queued;
    int unsigned vlen;
    int unsigned roll;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int p = 0; p < NumPhases; p++) begin
      if (p > 0) begin
        // mode only changes once every word has gone and the block has settled
        wait_until_drained();
        repeat (SettleCycles) @(posedge clk_i);
        cfg_we_i      <= 1'b1;
        cfg_wdata_i   <= phase_cfg[p];
        code_bits_cfg = phase_cfg[p];
        @(posedge clk_i);
        cfg_we_i <= 1'b0;
      end
      @(negedge clk_i);
      pending_codes.push_back('{7'h7f, 1'b0});
      pending_codes.push_back('{7'h00, 1'b1});
      queued = 0;
      while (queued < PhaseCodes) begin
        roll = $urandom_range(0, 9);
        if (roll < 3)      vlen = $urandom_range(1, 8);
        else if (roll < 6) vlen = $urandom_range(9, 40);
        else if (roll < 8) vlen = 16 << $urandom_range(0, 2);
        else               vlen = $urandom_range(65, 80);
        queue_codes(vlen, 1'b1);
        queued += vlen;
      end
      // unfinished group left across a mode change; before the first 4-bit phase it exceeds 16
      if (p == 3)
        queue_codes($urandom_range(17, 40), 1'b0);
      else if (p != NumPhases - 1 && $urandom_range(0, 1) == 1)
        queue_codes($urandom_range(1, 20), 1'b0);
    end
    wait_until_drained();
    repeat (SettleCycles) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/qcbp_pkg.sv
design/qcbp_front.sv
design/qcbp_grp_queue.sv
design/qcbp_back.sv
design/quantized_code_bit_packer.sv
test/quantized_code_bit_packer_tb.sv
